>>> hdl/pvd_pkg.sv
// pvd_pkg: shared constants, reset values and the beat type passed between the
// range lookup and the embed stages of the pixel-pair embedder
// no dependencies
`default_nettype none

package pvd_pkg;

  localparam int NUM_REGS = 8;
  localparam int PIX_W    = 8;
  localparam int LG_W     = 4;
  localparam int LG_MAX   = 8;
  // cumulative range end, up to eight ranges of 256
  localparam int END_W    = 12;
  // range top inside a selected range, at most 510
  localparam int TOP_W    = 9;
  // signed difference change, magnitude below 1024
  localparam int CHG_W    = 11;
  localparam int ADDR_W   = 5;
  localparam int IDX_W    = ADDR_W - 2;
  localparam int DATA_W   = 32;

  localparam logic [NUM_REGS-1:0][LG_W-1:0] LG_RST = {
    4'd0, 4'd0, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd3
  };

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t             p1;
    pix_t             p2;
    pix_t             msg;
    pix_t             ad;
    logic             neg;
    logic             found;
    pix_t             low;
    logic [TOP_W-1:0] top;
    logic [LG_W-1:0]  lg;
  } range_beat_t;

endpackage

`default_nettype wire

>>> hdl/pvd_cfg_regs.sv
// pvd_cfg_regs: range width registers on the bus port plus the registered
// table of cumulative range ends and clamped widths
// depends on pvd_pkg
`default_nettype none

module pvd_cfg_regs #(
  parameter int MAX_RANGES = 8
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire logic                                           psel,
  input  wire logic                                           penable,
  input  wire logic                                           pwrite,
  input  wire logic [pvd_pkg::ADDR_W-1:0]                     paddr,
  input  wire logic [pvd_pkg::DATA_W-1:0]                     pwdata,
  output logic      [pvd_pkg::DATA_W-1:0]                     prdata,
  output logic                                                pready,
  output logic      [MAX_RANGES-1:0][pvd_pkg::END_W-1:0]      ends,
  output logic      [MAX_RANGES-1:0][pvd_pkg::LG_W-1:0]       lgs
);
  import pvd_pkg::*;

  logic [NUM_REGS-1:0][LG_W-1:0]   lg_r;
  logic [IDX_W-1:0]                idx;
  logic [MAX_RANGES-1:0][END_W-1:0] ends_r, ends_nxt;
  logic [MAX_RANGES-1:0][LG_W-1:0]  lgs_r, lgs_nxt;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign prdata = DATA_W'(lg_r[idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r <= LG_RST;
    end else if (psel && penable && pwrite) begin
      lg_r[idx] <= pwdata[LG_W-1:0];
    end
  end

  // running sum of widths, widths above 256 act as 256
  always_comb begin
    logic [END_W-1:0] acc;
    logic [LG_W-1:0]  wc;
    acc = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      wc = (lg_r[i] > LG_W'(LG_MAX)) ? LG_W'(LG_MAX) : lg_r[i];
      acc = acc + (END_W'(1) << wc);
      ends_nxt[i] = acc;
      lgs_nxt[i]  = wc;
    end
  end

  always_ff @(posedge clk) begin
    ends_r <= ends_nxt;
    lgs_r  <= lgs_nxt;
  end

  assign ends = ends_r;
  assign lgs  = lgs_r;

endmodule

`default_nettype wire

>>> hdl/pvd_range_lookup.sv
// pvd_range_lookup: stage one forms |second - first|, stage two picks the
// first range whose end lies above it
// depends on pvd_pkg
`default_nettype none

module pvd_range_lookup #(
  parameter int MAX_RANGES = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      up_valid,
  output logic                                           up_stall,
  input  wire logic [pvd_pkg::PIX_W-1:0]                 p1,
  input  wire logic [pvd_pkg::PIX_W-1:0]                 p2,
  input  wire logic [pvd_pkg::PIX_W-1:0]                 msg,
  input  wire logic [MAX_RANGES-1:0][pvd_pkg::END_W-1:0] ends,
  input  wire logic [MAX_RANGES-1:0][pvd_pkg::LG_W-1:0]  lgs,
  output logic                                           dn_valid,
  input  wire logic                                      dn_ready,
  output pvd_pkg::range_beat_t                           dn_beat
);
  import pvd_pkg::*;

  logic        s1_v_r, s2_v_r;
  logic        s1_adv, s2_adv;
  pix_t        s1_p1_r, s1_p2_r, s1_msg_r, s1_ad_r;
  logic        s1_neg_r;
  logic [PIX_W:0] diff;
  pix_t        ad;
  range_beat_t s2_nxt, s2_r;

  assign s2_adv   = !s2_v_r || dn_ready;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign up_stall = !s1_adv;

  assign diff = {1'b0, p2} - {1'b0, p1};
  assign ad   = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_p1_r  <= p1;
      s1_p2_r  <= p2;
      s1_msg_r <= msg;
      s1_ad_r  <= ad;
      s1_neg_r <= diff[PIX_W];
    end
  end

  // first range with end above |d|; its base is the previous end
  always_comb begin
    logic [END_W-1:0] base;
    base         = '0;
    s2_nxt.p1    = s1_p1_r;
    s2_nxt.p2    = s1_p2_r;
    s2_nxt.msg   = s1_msg_r;
    s2_nxt.ad    = s1_ad_r;
    s2_nxt.neg   = s1_neg_r;
    s2_nxt.found = 1'b0;
    s2_nxt.low   = '0;
    s2_nxt.top   = '0;
    s2_nxt.lg    = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (!s2_nxt.found && (END_W'(s1_ad_r) < ends[i])) begin
        s2_nxt.found = 1'b1;
        s2_nxt.low   = base[PIX_W-1:0];
        s2_nxt.top   = TOP_W'(ends[i] - END_W'(1));
        s2_nxt.lg    = lgs[i];
      end
      base = ends[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign dn_valid = s2_v_r;
  assign dn_beat  = s2_r;

endmodule

`default_nettype wire

>>> hdl/pvd_embed.sv
// pvd_embed: stage three runs the falling-off test and forms the difference
// change, stage four splits it over the pixels into the output register
// depends on pvd_pkg
`default_nettype none

module pvd_embed (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      up_valid,
  output logic                           up_ready,
  input  wire pvd_pkg::range_beat_t      up_beat,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [pvd_pkg::PIX_W-1:0]      out_new_first,
  output logic [pvd_pkg::PIX_W-1:0]      out_new_second,
  output logic                           out_skipped,
  output logic [pvd_pkg::LG_W-1:0]       out_bits_used
);
  import pvd_pkg::*;

  typedef struct packed {
    pix_t                    p1;
    pix_t                    p2;
    logic                    even;
    logic                    skip;
    logic signed [CHG_W-1:0] chg;
    logic [LG_W-1:0]         lg;
  } chg_beat_t;

  logic        s3_v_r, out_v_r;
  logic        s3_adv, out_adv;
  chg_beat_t   s3_nxt, s3_r;

  logic [TOP_W-1:0]        c, lo_c, hi_c, sub_c, add_c;
  logic [TOP_W:0]          p2_top;
  logic                    fall, even;
  logic [TOP_W-1:0]        msk;
  pix_t                    m;
  logic [TOP_W-1:0]        mag;
  logic signed [CHG_W-1:0] dmag;

  logic signed [CHG_W-1:0] lo, hi;
  pix_t                    sub8, add8;
  pix_t                    nf_r, ns_r;
  logic                    skip_r;
  logic [LG_W-1:0]         lg_r;

  assign out_adv  = !out_v_r || !out_stall;
  assign s3_adv   = !s3_v_r || out_adv;
  assign up_ready = s3_adv;

  // parity of |d| picks which pixel takes the rounded-up half
  assign even  = !up_beat.ad[0];
  assign c     = up_beat.top - TOP_W'(up_beat.ad);
  assign lo_c  = c >> 1;
  assign hi_c  = c - lo_c;
  assign sub_c = even ? lo_c : hi_c;
  assign add_c = even ? hi_c : lo_c;
  assign p2_top = (TOP_W+1)'(up_beat.p2) + (TOP_W+1)'(add_c);
  assign fall  = (sub_c > TOP_W'(up_beat.p1)) || (p2_top > (TOP_W+1)'(255));

  assign msk  = (TOP_W'(1) << up_beat.lg) - TOP_W'(1);
  assign m    = up_beat.msg & msk[PIX_W-1:0];
  assign mag  = TOP_W'(up_beat.low) + TOP_W'(m);
  assign dmag = $signed(CHG_W'(mag)) - $signed(CHG_W'(up_beat.ad));

  always_comb begin
    s3_nxt.p1   = up_beat.p1;
    s3_nxt.p2   = up_beat.p2;
    s3_nxt.even = even;
    s3_nxt.skip = !up_beat.found || fall || (up_beat.lg == '0);
    // negative d: new difference and old one both flip sign
    s3_nxt.chg  = up_beat.neg ? -dmag : dmag;
    s3_nxt.lg   = up_beat.lg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_adv) begin
      s3_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_r <= s3_nxt;
    end
  end

  assign lo   = $signed(s3_r.chg) >>> 1;
  assign hi   = $signed(s3_r.chg) - lo;
  assign sub8 = s3_r.even ? lo[PIX_W-1:0] : hi[PIX_W-1:0];
  assign add8 = s3_r.even ? hi[PIX_W-1:0] : lo[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      nf_r   <= s3_r.skip ? '0 : s3_r.p1 - sub8;
      ns_r   <= s3_r.skip ? '0 : s3_r.p2 + add8;
      skip_r <= s3_r.skip;
      lg_r   <= s3_r.skip ? '0 : s3_r.lg;
    end
  end

  assign out_valid      = out_v_r;
  assign out_new_first  = nf_r;
  assign out_new_second = ns_r;
  assign out_skipped    = skip_r;
  assign out_bits_used  = lg_r;

endmodule

`default_nettype wire

>>> hdl/pvd_pair_embed.sv
// pvd_pair_embed: embeds message bits into one grey pixel pair per beat
// out_valid rises once a beat has passed the s1, s2 and s3 registers into the output register; out_stall delays it
// throughput: one pair per cycle while out_stall is low, four register stages with valid bits, the
// last one the output register; in_stall follows the stage occupancy chain
// reset: synchronous active-low rst_n empties the pipeline and loads the
// range registers with 3,3,4,5,6,7,0,0; a register write applies from the next beat
`default_nettype none

module pvd_pair_embed #(
  parameter int MAX_RANGES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pvd_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [pvd_pkg::DATA_W-1:0]    pwdata,
  output logic      [pvd_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  // pixel pair in
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pvd_pkg::PIX_W-1:0]     in_first_pixel,
  input  wire logic [pvd_pkg::PIX_W-1:0]     in_second_pixel,
  input  wire logic [pvd_pkg::PIX_W-1:0]     in_message_bits,
  // embedded pair out
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [pvd_pkg::PIX_W-1:0]     out_new_first,
  output logic      [pvd_pkg::PIX_W-1:0]     out_new_second,
  output logic                               out_skipped,
  output logic      [pvd_pkg::LG_W-1:0]      out_bits_used
);
  import pvd_pkg::*;

  // cumulative range ends and clamped log2 widths, registered once per
  // cycle from the range registers
  logic [MAX_RANGES-1:0][END_W-1:0] ends;
  logic [MAX_RANGES-1:0][LG_W-1:0]  lgs;

  // beat between the lookup half and the embed half
  logic        rng_valid;
  logic        rng_ready;
  range_beat_t rng_beat;

  pvd_cfg_regs #(
    .MAX_RANGES (MAX_RANGES)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ends    (ends),
    .lgs     (lgs)
  );

  // stages one and two: |d| and range select
  pvd_range_lookup #(
    .MAX_RANGES (MAX_RANGES)
  ) u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .p1       (in_first_pixel),
    .p2       (in_second_pixel),
    .msg      (in_message_bits),
    .ends     (ends),
    .lgs      (lgs),
    .dn_valid (rng_valid),
    .dn_ready (rng_ready),
    .dn_beat  (rng_beat)
  );

  // stages three and four: skip test, new difference, split and output
  pvd_embed u_embed (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (rng_valid),
    .up_ready       (rng_ready),
    .up_beat        (rng_beat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_new_first  (out_new_first),
    .out_new_second (out_new_second),
    .out_skipped    (out_skipped),
    .out_bits_used  (out_bits_used)
  );

endmodule

`default_nettype wire
